// ----- sv/movdec_pkg.sv -----
`default_nettype none

package movdec_pkg;

    // Instruction bytes held for one instruction.
    localparam int MaxBytes = 6;
    localparam logic [2:0] LastIdx = 3'(MaxBytes - 1);

    // Opcode masks and patterns.
    localparam logic [7:0] MaskRmReg  = 8'hfc;
    localparam logic [7:0] OpRmReg    = 8'h88;
    localparam logic [7:0] MaskOneBit = 8'hfe;
    localparam logic [7:0] OpImmRm    = 8'hc6;
    localparam logic [7:0] MaskNibble = 8'hf0;
    localparam logic [7:0] OpImmReg   = 8'hb0;
    localparam logic [7:0] OpMemAcc   = 8'ha0;
    localparam logic [7:0] OpAccMem   = 8'ha2;

    // Mod field codes and the r/m code of the direct address form.
    localparam logic [1:0] ModNoDisp  = 2'd0;
    localparam logic [1:0] ModDisp8   = 2'd1;
    localparam logic [1:0] ModDisp16  = 2'd2;
    localparam logic [2:0] RmDirect   = 3'd6;

    typedef enum logic [2:0] {
        KIND_RM_REG  = 3'd0,
        KIND_IMM_RM  = 3'd1,
        KIND_IMM_REG = 3'd2,
        KIND_MEM_ACC = 3'd3,
        KIND_ACC_MEM = 3'd4,
        KIND_UNSUP   = 3'd5
    } t_kind;

    typedef logic [7:0] t_bytes [MaxBytes];

    typedef struct packed {
        t_kind              op_kind;
        logic               dir_to_reg;
        logic               wide;
        logic [2:0]         reg_code;
        logic [1:0]         mode_code;
        logic [2:0]         rm_code;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [15:0]        abs_address;
        logic [2:0]         length;
    } t_result;

    // Sort an opcode byte into one of the MOV forms.
    function automatic t_kind classify(input logic [7:0] op);
        t_kind k;
        if ((op & MaskRmReg) == OpRmReg) begin
            k = KIND_RM_REG;
        end else if ((op & MaskOneBit) == OpImmRm) begin
            k = KIND_IMM_RM;
        end else if ((op & MaskNibble) == OpImmReg) begin
            k = KIND_IMM_REG;
        end else if ((op & MaskOneBit) == OpMemAcc) begin
            k = KIND_MEM_ACC;
        end else if ((op & MaskOneBit) == OpAccMem) begin
            k = KIND_ACC_MEM;
        end else begin
            k = KIND_UNSUP;
        end
        return k;
    endfunction

    // Total length of a mod/rm form once the mod/rm byte is known.
    function automatic logic [2:0] modrm_length(input logic [7:0] op,
                                                input logic [7:0] modrm);
        logic [2:0] n;
        n = 3'd2;
        if (modrm[7:6] == ModDisp8) begin
            n = 3'd3;
        end else if (modrm[7:6] == ModDisp16) begin
            n = 3'd4;
        end else if (modrm[7:6] == ModNoDisp && modrm[2:0] == RmDirect) begin
            n = 3'd4;
        end
        if (classify(op) == KIND_IMM_RM) begin
            n = n + (op[0] ? 3'd2 : 3'd1);
        end
        return n;
    endfunction

    // Build the decoded record from the collected instruction bytes.
    function automatic t_result decode(input t_bytes b, input logic [2:0] exp_len);
        t_result    r;
        t_kind      k;
        logic [2:0] p;
        r = '0;
        p = 3'd2;
        k = classify(b[0]);
        r.op_kind = k;
        case (k)
            KIND_RM_REG, KIND_IMM_RM: begin
                r.mode_code  = b[1][7:6];
                r.reg_code   = b[1][5:3];
                r.rm_code    = b[1][2:0];
                r.wide       = b[0][0];
                r.dir_to_reg = (k == KIND_RM_REG) ? b[0][1] : 1'b0;
                if (b[1][7:6] == ModDisp8) begin
                    r.displacement = {{8{b[2][7]}}, b[2]};
                    p = 3'd3;
                end else if (b[1][7:6] == ModDisp16) begin
                    r.displacement = {b[3], b[2]};
                    p = 3'd4;
                end else if (b[1][7:6] == ModNoDisp && b[1][2:0] == RmDirect) begin
                    r.abs_address = {b[3], b[2]};
                    p = 3'd4;
                end
                if (k == KIND_IMM_RM) begin
                    r.immediate = {(b[0][0] ? b[p + 3'd1] : 8'h00), b[p]};
                end
            end
            KIND_IMM_REG: begin
                r.wide       = b[0][3];
                r.reg_code   = b[0][2:0];
                r.dir_to_reg = 1'b1;
                r.immediate  = {(b[0][3] ? b[2] : 8'h00), b[1]};
            end
            KIND_MEM_ACC, KIND_ACC_MEM: begin
                r.wide        = b[0][0];
                r.dir_to_reg  = (k == KIND_MEM_ACC);
                r.abs_address = {b[2], b[1]};
            end
            default: begin
                r = '0;
                r.op_kind = KIND_UNSUP;
            end
        endcase
        r.length = (k == KIND_UNSUP) ? 3'd1 : exp_len;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mov_instruction_decoder.sv -----
`default_nettype none

// Decoder for the 8086 MOV forms, fed one instruction byte per word on the
// input channel. It takes a byte in every cycle while the result register is
// empty or being drained, collects the opcode, the mod/rm byte, the
// displacement, the immediate and the direct address, and works out the
// instruction length from the opcode and mod/rm byte. When the last byte of
// an instruction is taken, one decoded record appears on the output channel
// in the next cycle; an opcode that is not one of the five MOV forms
// (segment register moves included) gives a one-byte unsupported record at
// once. The rate is one byte per cycle, set by the single result register:
// a byte is held off only while a finished record waits to be taken.
module mov_instruction_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_in_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_op_kind,
    output logic                    o_dir_to_reg,
    output logic                    o_wide,
    output logic [2:0]              o_reg_code,
    output logic [1:0]              o_mode_code,
    output logic [2:0]              o_rm_code,
    output logic signed [15:0]      o_displacement,
    output logic [15:0]             o_immediate,
    output logic [15:0]             o_abs_address,
    output logic [2:0]              o_length
);

    logic [2:0]             r_idx;
    logic [2:0]             r_exp;
    logic [7:0]             r_bytes [movdec_pkg::MaxBytes];
    logic                   r_valid;
    movdec_pkg::t_result    r_out;

    logic                   accept;
    logic [2:0]             idx;
    logic [2:0]             n_exp;
    logic                   emit;
    movdec_pkg::t_bytes     view;
    movdec_pkg::t_kind      first_kind;
    movdec_pkg::t_result    n_out;

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Byte position of the incoming word, with an out-of-range count restarting.
    assign idx = (r_idx > movdec_pkg::LastIdx) ? 3'd0 : r_idx;

    // Collected bytes with the incoming word in its place.
    always_comb begin
        for (int i = 0; i < movdec_pkg::MaxBytes; i++) begin
            view[i] = (idx == 3'(i)) ? i_in_byte : r_bytes[i];
        end
    end

    // Length tracking and end-of-instruction detection.
    always_comb begin
        first_kind = movdec_pkg::classify(i_in_byte);
        n_exp = r_exp;
        emit  = 1'b0;
        if (idx == 3'd0) begin
            case (first_kind)
                movdec_pkg::KIND_UNSUP: begin
                    emit  = 1'b1;
                    n_exp = 3'd0;
                end
                movdec_pkg::KIND_IMM_REG: n_exp = i_in_byte[3] ? 3'd3 : 3'd2;
                movdec_pkg::KIND_MEM_ACC,
                movdec_pkg::KIND_ACC_MEM: n_exp = 3'd3;
                default: n_exp = 3'd0;
            endcase
        end else begin
            if (idx == 3'd1 && r_exp == 3'd0) begin
                n_exp = movdec_pkg::modrm_length(r_bytes[0], i_in_byte);
            end
            emit = (n_exp != 3'd0) && ({1'b0, idx} + 4'd1 >= {1'b0, n_exp});
        end
        n_out = movdec_pkg::decode(view, n_exp);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_exp   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (emit) begin
                    r_idx <= 3'd0;
                    r_exp <= 3'd0;
                end else begin
                    r_idx <= idx + 3'd1;
                    r_exp <= n_exp;
                end
            end
            if (accept && emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Byte store and result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes[idx] <= i_in_byte;
            if (emit) begin
                r_out <= n_out;
            end
        end
    end

    assign o_out_valid      = r_valid;
    assign o_op_kind        = r_out.op_kind;
    assign o_dir_to_reg     = r_out.dir_to_reg;
    assign o_wide           = r_out.wide;
    assign o_reg_code       = r_out.reg_code;
    assign o_mode_code      = r_out.mode_code;
    assign o_rm_code        = r_out.rm_code;
    assign o_displacement   = r_out.displacement;
    assign o_immediate      = r_out.immediate;
    assign o_abs_address    = r_out.abs_address;
    assign o_length         = r_out.length;

endmodule

`default_nettype wire

// ----- sv/movdec_chk.sv -----
`default_nettype none

module movdec_chk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [2:0]         o_op_kind,
    input  wire logic               o_dir_to_reg,
    input  wire logic               o_wide,
    input  wire logic [2:0]         o_reg_code,
    input  wire logic [1:0]         o_mode_code,
    input  wire logic [2:0]         o_rm_code,
    input  wire logic signed [15:0] o_displacement,
    input  wire logic [15:0]        o_immediate,
    input  wire logic [15:0]        o_abs_address,
    input  wire logic [2:0]         o_length
);

    // A stalled result word holds its kind, length and immediate.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_op_kind)
            && $stable(o_length) && $stable(o_immediate))
        else $error("result word changed while stalled");

    // A new result follows a byte taken in the cycle before.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result word appeared without a byte taken");

    // An unsupported opcode is one byte long with every field but the mod and r/m codes checked clear.
    a_unsup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op_kind == movdec_pkg::KIND_UNSUP |->
            o_length == 3'd1 && !o_wide && !o_dir_to_reg && o_reg_code == 3'd0
            && o_displacement == 16'sd0 && o_immediate == 16'd0
            && o_abs_address == 16'd0)
        else $error("unsupported record not cleared");

    // Immediate to register is two or three bytes by the w bit.
    a_immreg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op_kind == movdec_pkg::KIND_IMM_REG |->
            o_dir_to_reg && o_length == (o_wide ? 3'd3 : 3'd2)
            && o_mode_code == 2'd0 && o_rm_code == 3'd0)
        else $error("immediate to register record inconsistent");

    // Every record length lies between one and six bytes.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_length != 3'd0 && o_length != 3'd7)
        else $error("record length out of range");

endmodule

bind mov_instruction_decoder movdec_chk u_movdec_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_op_kind        (o_op_kind),
    .o_dir_to_reg     (o_dir_to_reg),
    .o_wide           (o_wide),
    .o_reg_code       (o_reg_code),
    .o_mode_code      (o_mode_code),
    .o_rm_code        (o_rm_code),
    .o_displacement   (o_displacement),
    .o_immediate      (o_immediate),
    .o_abs_address    (o_abs_address),
    .o_length         (o_length)
);

`default_nettype wire

// ----- test/mov_instruction_decoder_test.sv -----
`timescale 1ns / 100ps

module mov_instruction_decoder_test;

    // Segment register moves, which the block must report as unsupported.
    localparam logic [7:0] OpSegToRm   = 8'h8c;
    localparam logic [7:0] OpSegFromRm = 8'h8e;
    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned ReportMax  = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_in_byte = 8'h00;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [2:0]         o_op_kind;
    logic               o_dir_to_reg;
    logic               o_wide;
    logic [2:0]         o_reg_code;
    logic [1:0]         o_mode_code;
    logic [2:0]         o_rm_code;
    logic signed [15:0] o_displacement;
    logic [15:0]        o_immediate;
    logic [15:0]        o_abs_address;
    logic [2:0]         o_length;

    mov_instruction_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_op_kind       (o_op_kind),
        .o_dir_to_reg    (o_dir_to_reg),
        .o_wide          (o_wide),
        .o_reg_code      (o_reg_code),
        .o_mode_code     (o_mode_code),
        .o_rm_code       (o_rm_code),
        .o_displacement  (o_displacement),
        .o_immediate     (o_immediate),
        .o_abs_address   (o_abs_address),
        .o_length        (o_length)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state mirrored by the testbench.
    logic [7:0]          instr_buf [movdec_pkg::MaxBytes];
    int unsigned         buf_fill = 0;
    logic [2:0]          instr_len = 3'd0;
    movdec_pkg::t_result decoded_q [$];

    // Run bookkeeping.
    int unsigned         n_sent = 0;
    int unsigned         n_errors = 0;
    int unsigned         n_records = 0;
    int unsigned         kind_seen [6];
    int unsigned         idle_level = 0;
    int unsigned         stall_left = 0;
    int unsigned         cycle_count = 0;
    movdec_pkg::t_result want;
    string               bad_fields;

    // Sort an opcode byte into its MOV form.
    function automatic movdec_pkg::t_kind form_of(input logic [7:0] op);
        if ((op & movdec_pkg::MaskRmReg) == movdec_pkg::OpRmReg) begin
            return movdec_pkg::KIND_RM_REG;
        end
        if ((op & movdec_pkg::MaskOneBit) == movdec_pkg::OpImmRm) begin
            return movdec_pkg::KIND_IMM_RM;
        end
        if ((op & movdec_pkg::MaskNibble) == movdec_pkg::OpImmReg) begin
            return movdec_pkg::KIND_IMM_REG;
        end
        if ((op & movdec_pkg::MaskOneBit) == movdec_pkg::OpMemAcc) begin
            return movdec_pkg::KIND_MEM_ACC;
        end
        if ((op & movdec_pkg::MaskOneBit) == movdec_pkg::OpAccMem) begin
            return movdec_pkg::KIND_ACC_MEM;
        end
        return movdec_pkg::KIND_UNSUP;
    endfunction

    // Number of displacement or direct address bytes after a mod/rm byte.
    function automatic int unsigned addr_bytes(input logic [7:0] modrm);
        if (modrm[7:6] == movdec_pkg::ModDisp8) return 1;
        if (modrm[7:6] == movdec_pkg::ModDisp16) return 2;
        if (modrm[7:6] == movdec_pkg::ModNoDisp && modrm[2:0] == movdec_pkg::RmDirect) begin
            return 2;
        end
        return 0;
    endfunction

    // Build the decoded record from the bytes of the finished instruction.
    function automatic movdec_pkg::t_result decode_buf();
        movdec_pkg::t_result r;
        movdec_pkg::t_kind   k;
        int unsigned         p;
        r = '0;
        p = 2;
        k = form_of(instr_buf[0]);
        r.op_kind = k;
        r.length = instr_len;
        case (k)
            movdec_pkg::KIND_RM_REG, movdec_pkg::KIND_IMM_RM: begin
                {r.mode_code, r.reg_code, r.rm_code} = instr_buf[1];
                r.wide = instr_buf[0][0];
                if (k == movdec_pkg::KIND_RM_REG) begin
                    r.dir_to_reg = instr_buf[0][1];
                end
                if (r.mode_code == movdec_pkg::ModDisp8) begin
                    r.displacement = {{8{instr_buf[2][7]}}, instr_buf[2]};
                    p = 3;
                end else if (r.mode_code == movdec_pkg::ModDisp16) begin
                    r.displacement = {instr_buf[3], instr_buf[2]};
                    p = 4;
                end else if (r.mode_code == movdec_pkg::ModNoDisp
                             && r.rm_code == movdec_pkg::RmDirect) begin
                    r.abs_address = {instr_buf[3], instr_buf[2]};
                    p = 4;
                end
                if (k == movdec_pkg::KIND_IMM_RM) begin
                    r.immediate = {(r.wide ? instr_buf[p + 1] : 8'h00), instr_buf[p]};
                end
            end
            movdec_pkg::KIND_IMM_REG: begin
                r.wide = instr_buf[0][3];
                r.reg_code = instr_buf[0][2:0];
                r.dir_to_reg = 1'b1;
                r.immediate = {(r.wide ? instr_buf[2] : 8'h00), instr_buf[1]};
            end
            movdec_pkg::KIND_MEM_ACC, movdec_pkg::KIND_ACC_MEM: begin
                r.wide = instr_buf[0][0];
                r.dir_to_reg = (k == movdec_pkg::KIND_MEM_ACC);
                r.abs_address = {instr_buf[2], instr_buf[1]};
            end
            default: begin
                r.length = 3'd1;
            end
        endcase
        return r;
    endfunction

    // Take one accepted byte into the mirrored state and queue a record
    // once the instruction is complete.
    task automatic track_byte(input logic [7:0] b);
        instr_buf[buf_fill] = b;
        buf_fill++;
        if (buf_fill == 1) begin
            case (form_of(b))
                movdec_pkg::KIND_UNSUP: instr_len = 3'd1;
                movdec_pkg::KIND_IMM_REG: instr_len = b[3] ? 3'd3 : 3'd2;
                movdec_pkg::KIND_MEM_ACC, movdec_pkg::KIND_ACC_MEM: instr_len = 3'd3;
                default: instr_len = 3'd0;
            endcase
        end else if (buf_fill == 2 && instr_len == 3'd0) begin
            instr_len = 3'(2 + addr_bytes(b));
            if (form_of(instr_buf[0]) == movdec_pkg::KIND_IMM_RM) begin
                instr_len = instr_len + (instr_buf[0][0] ? 3'd2 : 3'd1);
            end
        end
        if (instr_len != 3'd0 && buf_fill >= instr_len) begin
            decoded_q.push_back(decode_buf());
            buf_fill = 0;
            instr_len = 3'd0;
        end
    endtask

    // Send one byte, maybe after a burst of idle cycles. Valid is left high
    // after the word is taken so that back to back bytes need no toggle.
    task automatic send_byte(input logic [7:0] b);
        if (idle_level != 0 && $urandom_range(0, 99) < idle_level) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        track_byte(b);
        n_sent++;
    endtask

    // Mostly random content, with the field extremes now and then.
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one well-formed MOV instruction of a random form.
    task automatic send_random_mov();
        logic [7:0]        op;
        logic [7:0]        modrm;
        logic [7:0]        seq [$];
        movdec_pkg::t_kind form;
        int unsigned       extra;
        form = movdec_pkg::t_kind'($urandom_range(0, 4));
        modrm = 8'($urandom_range(0, 255));
        extra = 0;
        case (form)
            movdec_pkg::KIND_RM_REG: begin
                op = movdec_pkg::OpRmReg | 8'($urandom_range(0, 3));
                extra = addr_bytes(modrm);
            end
            movdec_pkg::KIND_IMM_RM: begin
                op = movdec_pkg::OpImmRm | 8'($urandom_range(0, 1));
                extra = addr_bytes(modrm) + (op[0] ? 2 : 1);
            end
            movdec_pkg::KIND_IMM_REG: begin
                op = movdec_pkg::OpImmReg | 8'($urandom_range(0, 15));
                extra = op[3] ? 2 : 1;
            end
            movdec_pkg::KIND_MEM_ACC: begin
                op = movdec_pkg::OpMemAcc | 8'($urandom_range(0, 1));
                extra = 2;
            end
            default: begin
                op = movdec_pkg::OpAccMem | 8'($urandom_range(0, 1));
                extra = 2;
            end
        endcase
        seq.push_back(op);
        if (form == movdec_pkg::KIND_RM_REG || form == movdec_pkg::KIND_IMM_RM) begin
            seq.push_back(modrm);
        end
        repeat (extra) seq.push_back(any_byte());
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Noise: a stray byte, often a segment move, that may also start or
    // break an instruction.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_byte(OpSegToRm);
            1: send_byte(OpSegFromRm);
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // One instruction of each MOV form, with mod values, sign of the
    // displacement and immediate widths at their extremes.
    task automatic test_mov_forms();
        logic [7:0] seq [];
        seq = '{8'h89, 8'hd8,
                8'h8b, 8'h46, 8'h80,
                8'h88, 8'h87, 8'hff, 8'h7f,
                8'h8a, 8'h06, 8'h34, 8'h12,
                8'hc7, 8'h06, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hc6, 8'hc0, 8'h80,
                8'hbf, 8'h00, 8'h80,
                8'hb0, 8'hff,
                8'ha1, 8'h00, 8'h00,
                8'ha2, 8'hff, 8'hff};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Segment register moves and other opcodes outside the MOV set.
    task automatic test_unsupported_opcodes();
        send_byte(OpSegToRm);
        send_byte(OpSegFromRm);
        send_byte(8'h00);
        send_byte(8'hff);
    endtask

    // Random stream in chunks; each chunk picks its own idle density,
    // including none at all.
    task automatic test_random_stream(input int unsigned n_bytes);
        int unsigned start;
        int unsigned chunk_start;
        start = n_sent;
        chunk_start = n_sent;
        while (n_sent - start < n_bytes) begin
            if (n_sent - chunk_start >= 50) begin
                chunk_start = n_sent;
                case ($urandom_range(0, 2))
                    0: idle_level = 0;
                    1: idle_level = 10;
                    default: idle_level = 35;
                endcase
            end
            if ($urandom_range(0, 9) < 8) begin
                send_random_mov();
            end else begin
                send_noise();
            end
        end
    endtask

    // The sender holds off until every record has been taken, then resumes.
    task automatic test_drain_pause();
        repeat (3) begin
            repeat (6) send_random_mov();
            i_in_valid <= 1'b0;
            while (decoded_q.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    // Full rate on both sides for the last part of the run.
    task automatic test_full_rate_tail(input int unsigned n_bytes);
        int unsigned start;
        idle_level = 0;
        start = n_sent;
        while (n_sent - start < n_bytes) send_random_mov();
    endtask

    // The receiver stalls in random bursts whenever idling is enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (idle_level != 0 && $urandom_range(0, 99) < idle_level) begin
            stall_left <= $urandom_range(1, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every record taken from the block with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                n_errors++;
                if (n_errors <= ReportMax) begin
                    $display("[%0t] record with nothing pending: kind %0d length %0d",
                             $time, o_op_kind, o_length);
                end
            end else begin
                want = decoded_q.pop_front();
                n_records++;
                if (want.op_kind <= movdec_pkg::KIND_UNSUP) kind_seen[want.op_kind]++;
                bad_fields = "";
                if (o_op_kind !== want.op_kind) bad_fields = {bad_fields, " op_kind"};
                if (o_dir_to_reg !== want.dir_to_reg) bad_fields = {bad_fields, " dir_to_reg"};
                if (o_wide !== want.wide) bad_fields = {bad_fields, " wide"};
                if (o_reg_code !== want.reg_code) bad_fields = {bad_fields, " reg_code"};
                if (o_mode_code !== want.mode_code) bad_fields = {bad_fields, " mode_code"};
                if (o_rm_code !== want.rm_code) bad_fields = {bad_fields, " rm_code"};
                if (o_displacement !== want.displacement) begin
                    bad_fields = {bad_fields, " displacement"};
                end
                if (o_immediate !== want.immediate) bad_fields = {bad_fields, " immediate"};
                if (o_abs_address !== want.abs_address) begin
                    bad_fields = {bad_fields, " abs_address"};
                end
                if (o_length !== want.length) bad_fields = {bad_fields, " length"};
                if (bad_fields != "") begin
                    n_errors++;
                    if (n_errors <= ReportMax) begin
                        $display("[%0t] record mismatch in%s", $time, bad_fields);
                        $display("  expected kind %0d d %b w %b reg %0d mod %0d rm %0d",
                                 want.op_kind, want.dir_to_reg, want.wide,
                                 want.reg_code, want.mode_code, want.rm_code);
                        $display("           disp %0d imm %h addr %h len %0d",
                                 want.displacement, want.immediate,
                                 want.abs_address, want.length);
                        $display("  actual   kind %0d d %b w %b reg %0d mod %0d rm %0d",
                                 o_op_kind, o_dir_to_reg, o_wide,
                                 o_reg_code, o_mode_code, o_rm_code);
                        $display("           disp %0d imm %h addr %h len %0d",
                                 o_displacement, o_immediate, o_abs_address, o_length);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timed out after %0d cycles with %0d records pending",
                     cycle_count, decoded_q.size());
            $display("[mov_instruction_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        foreach (instr_buf[i]) instr_buf[i] = 8'h00;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mov_forms();
        test_unsupported_opcodes();
        idle_level = 20;
        test_random_stream(480);
        idle_level = 20;
        test_drain_pause();
        test_full_rate_tail(50);

        // Let the last records drain.
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        n_errors += decoded_q.size();

        $display("sent %0d bytes, checked %0d records with %0d failures",
                 n_sent, n_records, n_errors);
        $display("rm-reg %0d, imm-rm %0d, imm-reg %0d, mem-acc %0d, acc-mem %0d, unsup %0d",
                 kind_seen[movdec_pkg::KIND_RM_REG], kind_seen[movdec_pkg::KIND_IMM_RM],
                 kind_seen[movdec_pkg::KIND_IMM_REG], kind_seen[movdec_pkg::KIND_MEM_ACC],
                 kind_seen[movdec_pkg::KIND_ACC_MEM], kind_seen[movdec_pkg::KIND_UNSUP]);
        if (n_errors == 0) begin
            $display("[mov_instruction_decoder] OK");
        end else begin
            $display("[mov_instruction_decoder] ERROR");
        end
        $finish;
    end

endmodule
